/* rtl/core/spsu_pkg.sv */
// Shared types, codes and sizes for the stroke point smoother.
`default_nettype none

package spsu_pkg;

	localparam int CoordW        = 16;
	localparam int ExtraFracBits = 8;
	localparam int StateW        = CoordW + ExtraFracBits;

	localparam int QueueDepth = 2;
	localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	localparam int BatchMax  = 3;
	localparam int BatchCntW = $clog2(BatchMax + 1);

	localparam logic [1:0] ReqStart = 2'd0;
	localparam logic [1:0] ReqMove  = 2'd1;
	localparam logic [1:0] ReqEnd   = 2'd2;

	localparam logic [1:0] KindStart = 2'd0;
	localparam logic [1:0] KindMove  = 2'd1;
	localparam logic [1:0] KindEnd   = 2'd2;

	typedef enum logic [1:0] {
		OP_PASS  = 2'd0,
		OP_START = 2'd1,
		OP_MOVE  = 2'd2,
		OP_END   = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]               req_type;
		logic signed [CoordW-1:0] point_x;
		logic signed [CoordW-1:0] point_y;
	} req_t;

	typedef struct packed {
		logic signed [CoordW-1:0] out_x;
		logic signed [CoordW-1:0] out_y;
		logic [1:0]               point_kind;
		logic                     run_last;
	} pt_t;

	typedef struct packed {
		op_t                      op;
		logic [1:0]               kind;
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
	} cmd_t;

	typedef struct packed {
		logic [BatchCntW-1:0]   cnt;
		pt_t [BatchMax-1:0]     pts;
	} batch_t;

endpackage

`default_nettype wire

/* rtl/core/spsu_front.sv */
// Front end: request acceptance, enable register and request classification.
`default_nettype none

module spsu_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire spsu_pkg::req_t   req_data,
	input  wire logic             cfg_wr_en,
	input  wire logic             cfg_wr_data,
	input  wire logic             q_full,
	output logic                  q_push,
	output spsu_pkg::cmd_t        q_cmd
);

	logic enable_q;
	logic known_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_wr_en) begin
			enable_q <= cfg_wr_data;
		end
	end

	assign req_stall = q_full;

	// reserved request codes are taken and dropped
	assign known_req = (req_data.req_type == spsu_pkg::ReqStart) ||
		(req_data.req_type == spsu_pkg::ReqMove) ||
		(req_data.req_type == spsu_pkg::ReqEnd);

	assign q_push = req_valid && !q_full && known_req;

	always_comb begin
		q_cmd.kind = req_data.req_type;
		q_cmd.x    = req_data.point_x;
		q_cmd.y    = req_data.point_y;
		case (req_data.req_type)
			spsu_pkg::ReqStart: begin
				q_cmd.op = spsu_pkg::OP_START;
			end
			spsu_pkg::ReqMove: begin
				q_cmd.op = spsu_pkg::OP_MOVE;
			end
			spsu_pkg::ReqEnd: begin
				q_cmd.op = spsu_pkg::OP_END;
			end
			default: begin
				q_cmd.op = spsu_pkg::OP_PASS;
			end
		endcase
		if (!enable_q) begin
			q_cmd.op = spsu_pkg::OP_PASS;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/spsu_queue.sv */
// Short command queue between the front end and the arithmetic engine.
`default_nettype none

module spsu_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire spsu_pkg::cmd_t  push_cmd,
	output logic                 full,
	input  wire logic            pop,
	output logic                 nonempty,
	output spsu_pkg::cmd_t       head
);

	localparam int PtrW = spsu_pkg::QueuePtrW;
	localparam int CntW = spsu_pkg::QueueCntW;

	spsu_pkg::cmd_t      mem_q [spsu_pkg::QueueDepth];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     cnt_q;

	assign full     = (cnt_q == CntW'(spsu_pkg::QueueDepth));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == PtrW'(spsu_pkg::QueueDepth - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + PtrW'(1);
				end
			end
			if (pop) begin
				if (rd_ptr_q == PtrW'(spsu_pkg::QueueDepth - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + PtrW'(1);
				end
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/spsu_engine.sv */
// Arithmetic engine: sum, reciprocal multiply and correct, smoother state, batch build.
`default_nettype none

module spsu_engine (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire spsu_pkg::cmd_t   q_head,
	output logic                  q_pop,
	output logic                  load_valid,
	input  wire logic             load_ready,
	output spsu_pkg::batch_t      load_batch
);

	localparam int C  = spsu_pkg::CoordW;
	localparam int E  = spsu_pkg::ExtraFracBits;
	localparam int SW = spsu_pkg::StateW;

	localparam int DivA = 3;
	localparam int DivB = 9;
	localparam int DivC = 27;

	// signed width of each rounded, pre-shifted numerator
	localparam int T0W = SW + 3 - E;
	localparam int T1W = SW + 5 - E;
	localparam int T2W = SW + 6;
	// width of the offset, non-negative dividend
	localparam int S0 = T0W + 1;
	localparam int S1 = T1W + 1;
	localparam int S2 = T2W + 1;
	// adder widths ahead of the shift
	localparam int AW0 = SW + 6;
	localparam int AW1 = SW + 8;
	localparam int AW2 = SW + 9;
	localparam int QW  = S2 + 1;

	localparam longint K0 = ((longint'(1) <<< (T0W - 1)) + DivA - 1) / DivA;
	localparam longint K1 = ((longint'(1) <<< (T1W - 1)) + DivB - 1) / DivB;
	localparam longint K2 = ((longint'(1) <<< (T2W - 1)) + DivC - 1) / DivC;
	localparam longint Off0 = (K0 * DivA) <<< (E + 1);
	localparam longint Off1 = (K1 * DivB) <<< (E + 1);
	localparam longint Off2 = (K2 * DivC) <<< 1;
	localparam longint Rec0 = (longint'(1) <<< S0) / DivA;
	localparam longint Rec1 = (longint'(1) <<< S1) / DivB;
	localparam longint Rec2 = (longint'(1) <<< S2) / DivC;

	localparam logic signed [QW-1:0] CoordHi = QW'((longint'(1) <<< (C - 1)) - 1);
	localparam logic signed [QW-1:0] CoordLo = -CoordHi - QW'(1);
	localparam logic signed [QW-1:0] StateHi = QW'((longint'(1) <<< (SW - 1)) - 1);
	localparam logic signed [QW-1:0] StateLo = -StateHi - QW'(1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_FIX  = 4'b0100,
		ST_LOAD = 4'b1000
	} eng_state_t;

	function automatic logic signed [C-1:0] sat_coord(input logic signed [QW-1:0] v);
		if (v > CoordHi) begin
			return CoordHi[C-1:0];
		end
		if (v < CoordLo) begin
			return CoordLo[C-1:0];
		end
		return v[C-1:0];
	endfunction

	function automatic logic signed [SW-1:0] sat_state(input logic signed [QW-1:0] v);
		if (v > StateHi) begin
			return StateHi[SW-1:0];
		end
		if (v < StateLo) begin
			return StateLo[SW-1:0];
		end
		return v[SW-1:0];
	endfunction

	eng_state_t state_q;
	eng_state_t state_d;
	logic       load_fire;

	logic signed [SW-1:0]  smooth_q [2];
	logic signed [C-1:0]   prev_q [2];
	logic signed [C-1:0]   qin [2];
	logic signed [C-1:0]   raw_s2 [2];

	logic signed [AW0-1:0] sum0 [2];
	logic signed [AW1-1:0] sum1 [2];
	logic signed [AW2-1:0] sum2 [2];

	logic [S0-1:0]         m0_s1 [2];
	logic [S1-1:0]         m1_s1 [2];
	logic [S2-1:0]         m2_s1 [2];

	logic [2*S0-1:0]       prod0 [2];
	logic [2*S1-1:0]       prod1 [2];
	logic [2*S2-1:0]       prod2 [2];

	logic [S0-1:0]         m0_s2 [2];
	logic [S1-1:0]         m1_s2 [2];
	logic [S2-1:0]         m2_s2 [2];
	logic [S0-1:0]         qe0_s2 [2];
	logic [S1-1:0]         qe1_s2 [2];
	logic [S2-1:0]         qe2_s2 [2];

	logic [S0-1:0]         qu0 [2];
	logic [S1-1:0]         qu1 [2];
	logic [S2-1:0]         qu2 [2];
	logic signed [QW-1:0]  quo0 [2];
	logic signed [QW-1:0]  quo1 [2];
	logic signed [QW-1:0]  quo2 [2];
	logic signed [SW-1:0]  ns [2];

	logic signed [C-1:0]   r0_s3 [2];
	logic signed [C-1:0]   r1_s3 [2];
	logic signed [SW-1:0]  ns_s3 [2];
	logic signed [SW+1:0]  rnd2 [2];
	logic signed [C-1:0]   r2 [2];

	spsu_pkg::cmd_t cmd_s1;
	spsu_pkg::cmd_t cmd_s2;
	spsu_pkg::cmd_t cmd_s3;

	// one request in flight; the next enters while the finished batch is handed over
	assign load_valid = (state_q == ST_LOAD);
	assign load_fire  = load_valid && load_ready;
	assign q_pop      = q_valid && ((state_q == ST_IDLE) || load_fire);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_FIX;
			end
			ST_FIX: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (load_fire) begin
					state_d = q_pop ? ST_MUL : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign qin[0]    = q_head.x;
	assign qin[1]    = q_head.y;
	assign raw_s2[0] = cmd_s2.x;
	assign raw_s2[1] = cmd_s2.y;

	// numerators with rounding term and a bias that keeps the dividend non-negative
	always_comb begin
		for (int a = 0; a < 2; a++) begin
			sum0[a] = (AW0'(smooth_q[a]) <<< 2) + (AW0'(prev_q[a]) <<< (E + 1)) +
				AW0'(3 <<< E) + AW0'(Off0);
			sum1[a] = (AW1'(smooth_q[a]) <<< 3) + (AW1'(prev_q[a]) <<< (E + 3)) +
				(AW1'(qin[a]) <<< (E + 1)) + AW1'(9 <<< E) + AW1'(Off1);
			sum2[a] = (AW2'(smooth_q[a]) <<< 4) + (AW2'(qin[a]) <<< (E + 4)) +
				(AW2'(prev_q[a]) <<< (E + 4)) + (AW2'(prev_q[a]) <<< (E + 2)) +
				(AW2'(prev_q[a]) <<< (E + 1)) + AW2'(DivC) + AW2'(Off2);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1 <= q_head;
			for (int a = 0; a < 2; a++) begin
				m0_s1[a] <= sum0[a][E + 1 +: S0];
				m1_s1[a] <= sum1[a][E + 1 +: S1];
				m2_s1[a] <= sum2[a][1 +: S2];
			end
		end
	end

	// reciprocal estimates, low by at most one
	always_comb begin
		for (int a = 0; a < 2; a++) begin
			prod0[a] = (2 * S0)'(m0_s1[a]) * (2 * S0)'(Rec0);
			prod1[a] = (2 * S1)'(m1_s1[a]) * (2 * S1)'(Rec1);
			prod2[a] = (2 * S2)'(m2_s1[a]) * (2 * S2)'(Rec2);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			cmd_s2 <= cmd_s1;
			for (int a = 0; a < 2; a++) begin
				m0_s2[a]  <= m0_s1[a];
				m1_s2[a]  <= m1_s1[a];
				m2_s2[a]  <= m2_s1[a];
				qe0_s2[a] <= prod0[a][2 * S0 - 1 -: S0];
				qe1_s2[a] <= prod1[a][2 * S1 - 1 -: S1];
				qe2_s2[a] <= prod2[a][2 * S2 - 1 -: S2];
			end
		end
	end

	// bump the estimate when the remainder reaches the divisor, then drop the bias
	always_comb begin
		for (int a = 0; a < 2; a++) begin
			qu0[a] = qe0_s2[a] + S0'((m0_s2[a] - S0'(qe0_s2[a] * S0'(DivA))) >= S0'(DivA));
			qu1[a] = qe1_s2[a] + S1'((m1_s2[a] - S1'(qe1_s2[a] * S1'(DivB))) >= S1'(DivB));
			qu2[a] = qe2_s2[a] + S2'((m2_s2[a] - S2'(qe2_s2[a] * S2'(DivC))) >= S2'(DivC));
			quo0[a] = $signed(QW'(qu0[a])) - QW'(K0);
			quo1[a] = $signed(QW'(qu1[a])) - QW'(K1);
			quo2[a] = $signed(QW'(qu2[a])) - QW'(K2);
			ns[a]   = sat_state(quo2[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIX) begin
			cmd_s3 <= cmd_s2;
			for (int a = 0; a < 2; a++) begin
				r0_s3[a] <= sat_coord(quo0[a]);
				r1_s3[a] <= sat_coord(quo1[a]);
				ns_s3[a] <= ns[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 2; a++) begin
				smooth_q[a] <= '0;
				prev_q[a]   <= '0;
			end
		end else if (state_q == ST_FIX) begin
			for (int a = 0; a < 2; a++) begin
				if (cmd_s2.op == spsu_pkg::OP_START) begin
					smooth_q[a] <= SW'(raw_s2[a]) <<< E;
					prev_q[a]   <= raw_s2[a];
				end else if (cmd_s2.op == spsu_pkg::OP_MOVE || cmd_s2.op == spsu_pkg::OP_END) begin
					smooth_q[a] <= ns[a];
					prev_q[a]   <= raw_s2[a];
				end
			end
		end
	end

	// third point of a move: the new smoothed point rounded back to coordinate precision
	always_comb begin
		for (int a = 0; a < 2; a++) begin
			rnd2[a] = ((SW + 2)'(ns_s3[a]) <<< 1) + (SW + 2)'(1 <<< E);
			r2[a]   = sat_coord(QW'(rnd2[a] >>> (E + 1)));
		end
	end

	always_comb begin
		load_batch = '0;
		case (cmd_s3.op)
			spsu_pkg::OP_MOVE, spsu_pkg::OP_END: begin
				load_batch.cnt                = spsu_pkg::BatchCntW'(spsu_pkg::BatchMax);
				load_batch.pts[0].out_x       = r0_s3[0];
				load_batch.pts[0].out_y       = r0_s3[1];
				load_batch.pts[0].point_kind  = spsu_pkg::KindMove;
				load_batch.pts[0].run_last    = 1'b0;
				load_batch.pts[1].out_x       = r1_s3[0];
				load_batch.pts[1].out_y       = r1_s3[1];
				load_batch.pts[1].point_kind  = spsu_pkg::KindMove;
				load_batch.pts[1].run_last    = 1'b0;
				load_batch.pts[2].run_last    = 1'b1;
				if (cmd_s3.op == spsu_pkg::OP_END) begin
					load_batch.pts[2].out_x      = cmd_s3.x;
					load_batch.pts[2].out_y      = cmd_s3.y;
					load_batch.pts[2].point_kind = spsu_pkg::KindEnd;
				end else begin
					load_batch.pts[2].out_x      = r2[0];
					load_batch.pts[2].out_y      = r2[1];
					load_batch.pts[2].point_kind = spsu_pkg::KindMove;
				end
			end
			spsu_pkg::OP_START: begin
				load_batch.cnt               = spsu_pkg::BatchCntW'(1);
				load_batch.pts[0].out_x      = cmd_s3.x;
				load_batch.pts[0].out_y      = cmd_s3.y;
				load_batch.pts[0].point_kind = spsu_pkg::KindStart;
				load_batch.pts[0].run_last   = 1'b1;
			end
			default: begin
				load_batch.cnt               = spsu_pkg::BatchCntW'(1);
				load_batch.pts[0].out_x      = cmd_s3.x;
				load_batch.pts[0].out_y      = cmd_s3.y;
				load_batch.pts[0].point_kind = cmd_s3.kind;
				load_batch.pts[0].run_last   = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/spsu_emit.sv */
// Result buffer: holds one batch of points and sends them one per transfer.
`default_nettype none

module spsu_emit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load_valid,
	output logic                    load_ready,
	input  wire spsu_pkg::batch_t   load_batch,
	output logic                    pt_valid,
	input  wire logic               pt_stall,
	output spsu_pkg::pt_t           pt_data
);

	localparam int IdxW = $clog2(spsu_pkg::BatchMax);
	localparam int CntW = spsu_pkg::BatchCntW;

	spsu_pkg::pt_t [spsu_pkg::BatchMax-1:0] pts_q;
	logic [CntW-1:0] cnt_q;
	logic [IdxW-1:0] idx_q;
	logic            xfer;
	logic            load;

	assign pt_valid   = (cnt_q != '0);
	assign pt_data    = pts_q[idx_q];
	assign xfer       = pt_valid && !pt_stall;
	assign load_ready = (cnt_q == '0) || ((cnt_q == CntW'(1)) && !pt_stall);
	assign load       = load_valid && load_ready;

	always_ff @(posedge clk) begin
		if (load) begin
			pts_q <= load_batch.pts;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= load_batch.cnt;
			idx_q <= '0;
		end else if (xfer) begin
			cnt_q <= cnt_q - CntW'(1);
			idx_q <= idx_q + IdxW'(1);
		end
	end

endmodule

`default_nettype wire

/* rtl/core/stroke_point_smoother_unit.sv */
// Top level of the stroke point smoother.
`default_nettype none

// Smooths a pen stroke one point at a time. Requests enter on req_* (valid/stall):
// a start loads the smoothed point and the previous raw point and passes the point
// through; a move emits three points, (2s+p)/3, (4(s+p)+q)/9 and the new smoothed
// point (8(s+q)+11p)/27; an end does the same but sends the raw point as its third,
// marked as the end. Reserved request codes are taken and dropped. Points leave on
// pt_* (valid/stall) in Q12.4, rounded half up and saturated; run_last marks the last
// point of each request. With smoothing_enable (cfg_wr_en / cfg_wr_data, reset 1)
// cleared, each known request passes its point through once and the state is held;
// write it only while the block is idle. The engine takes one request at a time
// through its three-step sum / reciprocal multiply / correct sequence, whose
// result the next request depends on; the three points of a move leave on
// consecutive cycles when not stalled, while the next request is being worked.
// A two-entry queue decouples request intake from the engine, and a batch buffer
// decouples the engine from the output, so either side may stall without blocking
// the other at once.
module stroke_point_smoother_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire spsu_pkg::req_t   req_data,
	output logic                  pt_valid,
	input  wire logic             pt_stall,
	output spsu_pkg::pt_t         pt_data,
	input  wire logic             cfg_wr_en,
	input  wire logic             cfg_wr_data
);

	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_nonempty;
	spsu_pkg::cmd_t   q_cmd;
	spsu_pkg::cmd_t   q_head;
	logic             load_valid;
	logic             load_ready;
	spsu_pkg::batch_t load_batch;

	// classify and push each request transfer
	spsu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_data    (req_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (q_cmd)
	);

	// hold classified requests until the engine is free
	spsu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	// compute the points and advance the smoother state
	spsu_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_nonempty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.load_valid (load_valid),
		.load_ready (load_ready),
		.load_batch (load_batch)
	);

	// drain each batch, one point per output transfer
	spsu_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (load_valid),
		.load_ready (load_ready),
		.load_batch (load_batch),
		.pt_valid   (pt_valid),
		.pt_stall   (pt_stall),
		.pt_data    (pt_data)
	);

endmodule

`default_nettype wire

/* rtl/core/spsu_checker.sv */
// Port-level checks of the stroke point smoother, bound to its top level.
`default_nettype none

module spsu_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            pt_valid,
	input wire logic            pt_stall,
	input wire spsu_pkg::pt_t   pt_data
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && pt_stall |=> pt_valid && $stable(pt_data))
		else $error("stalled point changed or dropped");

	a_single_kinds_last: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && (pt_data.point_kind == spsu_pkg::KindStart ||
			pt_data.point_kind == spsu_pkg::KindEnd) |-> pt_data.run_last)
		else $error("start or end point not marked last");

	a_inner_is_move: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && !pt_data.run_last |-> pt_data.point_kind == spsu_pkg::KindMove)
		else $error("inner point of a batch is not a move point");

	a_batch_continues: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && !pt_stall && !pt_data.run_last |=> pt_valid)
		else $error("batch broken after an inner point");

	a_batch_of_three: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && !pt_stall && !pt_data.run_last &&
			$past(pt_valid && !pt_stall && !pt_data.run_last) |=> pt_data.run_last)
		else $error("third point of a batch not marked last");

endmodule

bind stroke_point_smoother_unit spsu_checker u_spsu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pt_valid (pt_valid),
	.pt_stall (pt_stall),
	.pt_data  (pt_data)
);

`default_nettype wire

/* bench/stroke_point_smoother_unit_tb.sv */
// Testbench for stroke_point_smoother_unit: random pen strokes checked against a scoreboard.
module stroke_point_smoother_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Request code 3 is reserved: the block takes it and drops it.
	localparam logic [1:0] ReqReserved = 2'd3;

	// Generous bound on the whole run, far above the slowest legal run.
	localparam int CycleLimit = 400000;

	// Cycles to let pass once nothing is expected: covers the path through the intake
	// queue and the engine, so a dropped request cannot still be in flight.
	localparam int SettleCycles = 16;

	// Scoreboard: keeps its own copy of the smoothing state and the enable bit,
	// turns every accepted request into the points it must cause, and checks
	// each transferred point against the oldest one still waiting.
	class point_scoreboard;
		bit              enable;
		longint          smooth_x, smooth_y;
		longint          prev_x, prev_y;
		spsu_pkg::pt_t   pending_pts[$];
		int              errors;

		function new();
			enable   = 1'b1;
			smooth_x = 0;
			smooth_y = 0;
			prev_x   = 0;
			prev_y   = 0;
			errors   = 0;
		endfunction

		function void set_enable(bit value);
			enable = value;
		endfunction

		function int pending();
			return pending_pts.size();
		endfunction

		function longint clamp(longint v, int w);
			longint hi;
			longint lo;
			hi = (longint'(1) <<< (w - 1)) - 1;
			lo = -hi - 1;
			if (v > hi) return hi;
			if (v < lo) return lo;
			return v;
		endfunction

		function longint floor_div(longint n, longint d);
			longint q;
			q = n / d;
			if ((n % d) != 0 && n < 0) q = q - 1;
			return q;
		endfunction

		// Divide and round half up, ties toward plus infinity.
		function longint div_round(longint n, longint d);
			return floor_div(2 * n + d, 2 * d);
		endfunction

		// One axis of a move: the two in-between points, the new smoothed point,
		// and the state update.
		function void smooth_axis(inout longint s, inout longint p, input longint q,
				output longint r0, output longint r1, output longint r2);
			longint one;
			longint sv, pv, qv, ns;
			one = longint'(1) <<< spsu_pkg::ExtraFracBits;
			sv  = s;
			pv  = p * one;
			qv  = q * one;
			r0  = div_round(2 * sv + pv, 3 * one);
			r1  = div_round(4 * (sv + pv) + qv, 9 * one);
			ns  = clamp(div_round(8 * (sv + qv) + 11 * pv, 27), spsu_pkg::StateW);
			r2  = div_round(ns, one);
			s   = ns;
			p   = q;
		endfunction

		function void push_point(longint x, longint y, logic [1:0] kind, bit last);
			spsu_pkg::pt_t e;
			e.out_x      = spsu_pkg::CoordW'(clamp(x, spsu_pkg::CoordW));
			e.out_y      = spsu_pkg::CoordW'(clamp(y, spsu_pkg::CoordW));
			e.point_kind = kind;
			e.run_last   = last;
			pending_pts = {pending_pts, e};
		endfunction

		function void note_request(spsu_pkg::req_t r);
			longint x, y;
			longint x0, x1, x2, y0, y1, y2;
			logic [1:0] kind;
			x = longint'($signed(r.point_x));
			y = longint'($signed(r.point_y));
			if (r.req_type == ReqReserved) return;
			if (!enable) begin
				// Pass through once, state untouched.
				case (r.req_type)
					spsu_pkg::ReqStart: kind = spsu_pkg::KindStart;
					spsu_pkg::ReqMove:  kind = spsu_pkg::KindMove;
					default:            kind = spsu_pkg::KindEnd;
				endcase
				push_point(x, y, kind, 1'b1);
				return;
			end
			if (r.req_type == spsu_pkg::ReqStart) begin
				smooth_x = x * (longint'(1) <<< spsu_pkg::ExtraFracBits);
				smooth_y = y * (longint'(1) <<< spsu_pkg::ExtraFracBits);
				prev_x   = x;
				prev_y   = y;
				push_point(x, y, spsu_pkg::KindStart, 1'b1);
				return;
			end
			smooth_axis(smooth_x, prev_x, x, x0, x1, x2);
			smooth_axis(smooth_y, prev_y, y, y0, y1, y2);
			push_point(x0, y0, spsu_pkg::KindMove, 1'b0);
			push_point(x1, y1, spsu_pkg::KindMove, 1'b0);
			// An end sends the raw point last; the state still advances as for a move.
			if (r.req_type == spsu_pkg::ReqEnd)
				push_point(x, y, spsu_pkg::KindEnd, 1'b1);
			else
				push_point(x2, y2, spsu_pkg::KindMove, 1'b1);
		endfunction

		function void check_point(spsu_pkg::pt_t got);
			spsu_pkg::pt_t e;
			if (pending_pts.size() == 0) begin
				$error("unexpected point: x %0d y %0d kind %0d last %0d",
					$signed(got.out_x), $signed(got.out_y), got.point_kind, got.run_last);
				errors++;
				return;
			end
			e = pending_pts.pop_front();
			if (got.out_x !== e.out_x) begin
				$error("out_x: expected %0d, got %0d", $signed(e.out_x), $signed(got.out_x));
				errors++;
			end
			if (got.out_y !== e.out_y) begin
				$error("out_y: expected %0d, got %0d", $signed(e.out_y), $signed(got.out_y));
				errors++;
			end
			if (got.point_kind !== e.point_kind) begin
				$error("point_kind: expected %0d, got %0d", e.point_kind, got.point_kind);
				errors++;
			end
			if (got.run_last !== e.run_last) begin
				$error("run_last: expected %0d, got %0d", e.run_last, got.run_last);
				errors++;
			end
		endfunction
	endclass

	logic           clk;
	logic           arst_n      = 1'b0;
	logic           req_valid   = 1'b0;
	logic           req_stall;
	spsu_pkg::req_t req_data    = '0;
	logic           pt_valid;
	logic           pt_stall    = 1'b0;
	spsu_pkg::pt_t  pt_data;
	logic           cfg_wr_en   = 1'b0;
	logic           cfg_wr_data = 1'b0;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int cycle_count = 0;

	point_scoreboard sb = new();

	stroke_point_smoother_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_data    (req_data),
		.pt_valid    (pt_valid),
		.pt_stall    (pt_stall),
		.pt_data     (pt_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: end the run as failed once the cycle count hits the limit.
	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Receiver side: stall at random at the current idle rate.
	always @(posedge clk) begin
		pt_stall <= arst_n && ($urandom_range(0, 99) < rx_idle_pct);
	end

	// Sample at the falling edge, where inputs and outputs are settled; a point
	// seen valid and not stalled here is transferred at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && pt_valid && !pt_stall) sb.check_point(pt_data);
	end

	// Random coordinate near base: mostly small pen steps, sometimes jumps, now and
	// then a full-range value or an extreme.
	function automatic int next_coord(int base);
		int pick;
		int v;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			v = int'($urandom_range(0, 65535)) - 32768;
		else if (pick == 1)
			v = $urandom_range(0, 1) ? 32767 : -32768;
		else if (pick < 5)
			v = base + int'($urandom_range(0, 2048)) - 1024;
		else
			v = base + int'($urandom_range(0, 64)) - 32;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	task automatic set_idling(int tx_pct, int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
	endtask

	// Offer one request and hold it until the transfer; note it on acceptance.
	// Called and returns at a rising edge.
	task automatic send_request(logic [1:0] code, int x, int y);
		spsu_pkg::req_t r;
		bit             taken;
		r.req_type = code;
		r.point_x  = spsu_pkg::CoordW'(x);
		r.point_y  = spsu_pkg::CoordW'(y);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !req_stall;
			@(posedge clk);
		end
		sb.note_request(r);
	endtask

	// Drop valid, wait for every expected point, then let the block settle.
	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_enable(bit value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		sb.set_enable(value);
		cfg_wr_en   <= 1'b0;
	endtask

	// Mostly whole strokes with random content; the rest is loose requests of any
	// code, including moves and ends with no start and the reserved code.
	task automatic run_strokes(int count);
		int sent;
		int len;
		int px, py;
		logic [1:0] code;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 82) begin
				px = next_coord(int'($urandom_range(0, 65535)) - 32768);
				py = next_coord(int'($urandom_range(0, 65535)) - 32768);
				send_request(spsu_pkg::ReqStart, px, py);
				sent++;
				len = $urandom_range(0, 10);
				repeat (len) begin
					px = next_coord(px);
					py = next_coord(py);
					send_request(spsu_pkg::ReqMove, px, py);
					sent++;
				end
				// Leave some strokes open: the next start must reload the state.
				if ($urandom_range(0, 9) < 8) begin
					send_request(spsu_pkg::ReqEnd, next_coord(px), next_coord(py));
					sent++;
				end
			end else begin
				code = 2'($urandom_range(0, 3));
				send_request(code, int'($urandom_range(0, 65535)) - 32768,
					int'($urandom_range(0, 65535)) - 32768);
				if (code != ReqReserved) sent++;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_enable(1'b1);
		set_idling(23, 53);

		// Move and end with no start since reset: run on the zero state.
		send_request(spsu_pkg::ReqMove, 100, -50);
		send_request(spsu_pkg::ReqEnd, -7, 9);
		send_request(ReqReserved, 32767, -32768);
		// Strokes between the corners of the coordinate range.
		send_request(spsu_pkg::ReqStart, 32767, 32767);
		send_request(spsu_pkg::ReqMove, 32767, 32767);
		send_request(spsu_pkg::ReqMove, -32768, -32768);
		send_request(spsu_pkg::ReqEnd, -32768, 32767);
		send_request(spsu_pkg::ReqStart, -32768, -32768);
		send_request(spsu_pkg::ReqMove, 32767, 32767);
		// Reserved code in the middle of a stroke must leave the state alone.
		send_request(ReqReserved, 0, 0);
		send_request(spsu_pkg::ReqEnd, 32767, -32768);
		// Tiny steps around zero exercise rounding of negative values.
		send_request(spsu_pkg::ReqStart, 0, 0);
		send_request(spsu_pkg::ReqMove, 1, -1);
		send_request(spsu_pkg::ReqMove, -1, 2);
		send_request(spsu_pkg::ReqMove, 3, -3);
		send_request(spsu_pkg::ReqEnd, 0, 0);
		// Start followed straight by end.
		send_request(spsu_pkg::ReqStart, -1, -1);
		send_request(spsu_pkg::ReqEnd, 1, 1);

		run_strokes(190);

		// Pass-through mode: each code once, start and move at the extremes, then random traffic.
		drain();
		write_enable(1'b0);
		send_request(spsu_pkg::ReqStart, 32767, -32768);
		send_request(spsu_pkg::ReqMove, -32768, 32767);
		send_request(spsu_pkg::ReqEnd, 0, -1);
		send_request(ReqReserved, 5, 5);
		run_strokes(50);

		// Back to smoothing, with the idle rates swapped.
		drain();
		write_enable(1'b1);
		set_idling(53, 23);
		run_strokes(130);

		// Full speed on both sides, through both settings again.
		drain();
		write_enable(1'b0);
		set_idling(0, 0);
		run_strokes(20);
		drain();
		write_enable(1'b1);
		run_strokes(60);

		drain();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
